[rtl/vpo_pkg.sv]
// vpo_pkg: shared widths, codes, stage payload types and the 2^(2^-n) root table
// for the volt-per-octave converter; no dependencies
`default_nettype none

package vpo_pkg;

  // field and port widths
  localparam int CV_W       = 21;
  localparam int OUT_W      = 44;
  localparam int MODE_W     = 2;
  localparam int SHIFT_W    = 3;
  localparam int RATE_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // internal widths
  localparam int FRAC_W    = 16;              // fractional exponent bits
  localparam int EXP_W     = 23;              // signed exponent, q.16
  localparam int IP_W      = EXP_W - FRAC_W;  // integer part of exponent
  localparam int TSH_W     = 8;               // signed mantissa shift
  localparam int MANT_W    = 31;              // mantissa, q1.30
  localparam int MANT_FRAC = 30;
  localparam int PROD_W    = 2 * MANT_W;
  localparam int DEN_W     = 19;              // doubled divisor
  localparam int X_W       = 64;              // shifted mantissa
  localparam int ACC_W     = X_W + 1;         // dividend after rounding add
  localparam int HI_W      = ACC_W - OUT_W;   // dividend bits above the quotient
  localparam int DIV_STEP  = 4;               // quotient bits per divider stage

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd2;

  // output modes
  localparam logic [MODE_W-1:0] MODE_HZ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NYQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_20K = 2'd2;

  // reset values
  localparam logic [MODE_W-1:0]  MODE_RST  = MODE_HZ;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd0;
  localparam logic [RATE_W-1:0]  RATE_RST  = 18'd44100;

  // arithmetic constants
  localparam logic signed [EXP_W-1:0] EXP_OFFSET = 23'sd329737;  // 5.0313842 in q.16
  localparam logic [TSH_W-1:0]  TSH_BIAS_NYQ = 8'd4;
  localparam logic [TSH_W-1:0]  TSH_BIAS     = 8'd5;
  localparam logic [TSH_W-2:0]  TSH_MAX      = 7'd33;   // larger left shift saturates
  localparam logic [DEN_W-1:0]  DEN_HZ       = 19'd2;
  localparam logic [DEN_W-1:0]  DEN_20K      = 19'd40000;
  localparam logic [MANT_W-1:0] MANT_ONE     = 31'h4000_0000;
  localparam logic [PROD_W-1:0] PROD_RND     = PROD_W'(1) << (MANT_FRAC - 1);
  localparam logic [OUT_W-1:0]  OUT_MAX      = {OUT_W{1'b1}};

  typedef logic [MANT_W-1:0] vpo_root_tab_t [FRAC_W];

  typedef struct packed {
    logic [TSH_W-1:0] tsh;   // two's complement shift of the mantissa
    logic [DEN_W-1:0] den;   // twice the divisor
    logic             zero;  // unused mode
    logic             sat;   // force maximum
  } vpo_ctl_t;

  typedef struct packed {
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    vpo_ctl_t          ctl;
  } vpo_mul_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    vpo_ctl_t       ctl;
  } vpo_shf_t;

  typedef struct packed {
    logic [ACC_W-1:0] a;
    vpo_ctl_t         ctl;
  } vpo_add_t;

  typedef struct packed {
    logic [OUT_W-1:0] qa;    // remaining dividend bits on top, quotient enters below
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             zero;
    logic             sat;
  } vpo_div_t;

  // floor square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem_v;
    logic [63:0] res_v;
    logic [63:0] bit_v;
    int          i;
    rem_v = x;
    res_v = '0;
    bit_v = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bit_v > rem_v) begin
        bit_v = bit_v >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bit_v != '0) begin
        if (rem_v >= res_v + bit_v) begin
          rem_v = rem_v - (res_v + bit_v);
          res_v = (res_v >> 1) + bit_v;
        end else begin
          res_v = res_v >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res_v;
  endfunction

  // entry k is 2^(2^-(k+1)) in q1.30 by repeated floor square roots
  function automatic vpo_root_tab_t root_table();
    vpo_root_tab_t tab;
    logic [63:0]   r;
    int            k;
    r = isqrt64(64'd1 << 61);
    for (k = 0; k < FRAC_W; k++) begin
      tab[k] = r[MANT_W-1:0];
      r      = isqrt64(r << MANT_FRAC);
    end
    return tab;
  endfunction

  localparam vpo_root_tab_t ROOT_TAB = root_table();

endpackage

`default_nettype wire

[rtl/volt_per_octave_to_frequency.sv]
// volt_per_octave_to_frequency: exp2 converter, q4.16 volts in, q20.24 out; uses vpo_pkg
// throughput: one transaction per clock while in_stall is low; pipeline of 16 multiplier
//   stages (one per exponent fraction bit) and 11 divider stages (4 quotient bits each)
//   plus exponent, shift, round and range stages, ahead of the output register
// reset: synchronous active-low rst_n empties pipeline, output register and skid slot,
//   and loads mode 0 (Hz), octave shift 0, sample rate 44100
`default_nettype none

module volt_per_octave_to_frequency (
  input  logic                             clk,
  input  logic                             rst_n,
  // input transactions
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [vpo_pkg::CV_W-1:0]  in_cv_sample,
  // result transactions
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [vpo_pkg::OUT_W-1:0]        out_converted,
  // register writes
  input  logic                             cfg_wr_en,
  input  logic [vpo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int MulStg = vpo_pkg::FRAC_W;
  localparam int DivStg = vpo_pkg::OUT_W / vpo_pkg::DIV_STEP;
  // exponent, multipliers, shift, round add, range check, divider
  localparam int NumStg = 1 + MulStg + 3 + DivStg;

  // configuration registers
  logic [vpo_pkg::MODE_W-1:0]         mode_r;
  logic signed [vpo_pkg::SHIFT_W-1:0] shift_r;
  logic [vpo_pkg::RATE_W-1:0]         rate_r;

  // pipeline valid flags, one per stage, and the global advance
  logic [NumStg-1:0] vld_r;
  logic              adv;
  logic              push;

  // stage payloads
  vpo_pkg::vpo_mul_t mul_r   [MulStg+1];
  vpo_pkg::vpo_mul_t mul_nxt [MulStg+1];
  vpo_pkg::vpo_shf_t shf_r;
  vpo_pkg::vpo_shf_t shf_nxt;
  vpo_pkg::vpo_add_t add_r;
  vpo_pkg::vpo_add_t add_nxt;
  vpo_pkg::vpo_div_t div_r   [DivStg+1];
  vpo_pkg::vpo_div_t div_nxt [DivStg+1];

  // output register and skid slot
  logic                      out_vld_r;
  logic                      out_vld_nxt;
  logic [vpo_pkg::OUT_W-1:0] out_q_r;
  logic [vpo_pkg::OUT_W-1:0] out_q_nxt;
  logic                      skid_vld_r;
  logic                      skid_vld_nxt;
  logic [vpo_pkg::OUT_W-1:0] skid_q_r;
  logic [vpo_pkg::OUT_W-1:0] skid_q_nxt;
  logic [vpo_pkg::OUT_W-1:0] res;

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= vpo_pkg::MODE_RST;
      shift_r <= vpo_pkg::SHIFT_RST;
      rate_r  <= vpo_pkg::RATE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vpo_pkg::REG_MODE:  mode_r  <= cfg_wdata[vpo_pkg::MODE_W-1:0];
        vpo_pkg::REG_SHIFT: shift_r <= cfg_wdata[vpo_pkg::SHIFT_W-1:0];
        vpo_pkg::REG_RATE:  rate_r  <= cfg_wdata[vpo_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline moves unless the skid slot is occupied; the skid slot lets
  // one more result leave the pipeline while the output register is held
  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign push     = adv && vld_r[NumStg-1];

  // exponent stage and the fractional exp2 chain
  always_comb begin
    logic signed [vpo_pkg::EXP_W-1:0]  e_sum;
    logic [vpo_pkg::IP_W-1:0]          ip;
    logic [vpo_pkg::PROD_W-1:0]        prod;
    int                                k;

    // exponent = cv + octave shift + offset, split into integer and fraction
    e_sum = vpo_pkg::EXP_W'(in_cv_sample)
          + (vpo_pkg::EXP_W'(shift_r) <<< vpo_pkg::FRAC_W)
          + vpo_pkg::EXP_OFFSET;
    ip    = e_sum[vpo_pkg::EXP_W-1:vpo_pkg::FRAC_W];

    mul_nxt[0].mant     = vpo_pkg::MANT_ONE;
    mul_nxt[0].frac     = e_sum[vpo_pkg::FRAC_W-1:0];
    mul_nxt[0].ctl.zero = 1'b0;
    mul_nxt[0].ctl.sat  = 1'b0;
    // mantissa shift carries one extra bit so that rounding becomes (x + d) / 2d
    mul_nxt[0].ctl.tsh  = {ip[vpo_pkg::IP_W-1], ip} - vpo_pkg::TSH_BIAS;
    case (mode_r)
      vpo_pkg::MODE_HZ: begin
        mul_nxt[0].ctl.den = vpo_pkg::DEN_HZ;
      end
      vpo_pkg::MODE_NYQ: begin
        mul_nxt[0].ctl.den = {rate_r, 1'b0};
        mul_nxt[0].ctl.tsh = {ip[vpo_pkg::IP_W-1], ip} - vpo_pkg::TSH_BIAS_NYQ;
        // zero sample rate saturates
        mul_nxt[0].ctl.sat = (rate_r == '0);
      end
      vpo_pkg::MODE_20K: begin
        mul_nxt[0].ctl.den = vpo_pkg::DEN_20K;
      end
      default: begin
        // unused mode gives zero
        mul_nxt[0].ctl.den  = vpo_pkg::DEN_HZ;
        mul_nxt[0].ctl.zero = 1'b1;
      end
    endcase

    // one rounded q1.30 multiply per fraction bit, msb first
    for (k = 0; k < MulStg; k++) begin
      prod = vpo_pkg::PROD_W'(mul_r[k].mant) * vpo_pkg::PROD_W'(vpo_pkg::ROOT_TAB[k])
           + vpo_pkg::PROD_RND;
      mul_nxt[k+1] = mul_r[k];
      if (mul_r[k].frac[MulStg-1-k]) begin
        mul_nxt[k+1].mant = prod[vpo_pkg::MANT_FRAC +: vpo_pkg::MANT_W];
      end
    end
  end

  // binary point shift, then the rounding add
  always_comb begin
    logic [vpo_pkg::TSH_W-1:0] tsh;
    logic [vpo_pkg::TSH_W-1:0] nsh;
    tsh = mul_r[MulStg].ctl.tsh;
    nsh = -tsh;

    shf_nxt.ctl = mul_r[MulStg].ctl;
    if (tsh[vpo_pkg::TSH_W-1]) begin
      // right shifts past the mantissa width leave nothing
      if (nsh[vpo_pkg::TSH_W-1:5] != '0) begin
        shf_nxt.x = '0;
      end else begin
        shf_nxt.x = vpo_pkg::X_W'(mul_r[MulStg].mant) >> nsh[4:0];
      end
    end else begin
      shf_nxt.x = vpo_pkg::X_W'(mul_r[MulStg].mant) << tsh[5:0];
      if (tsh[vpo_pkg::TSH_W-2:0] > vpo_pkg::TSH_MAX) begin
        shf_nxt.ctl.sat = 1'b1;
      end
    end

    add_nxt.ctl = shf_r.ctl;
    add_nxt.a   = vpo_pkg::ACC_W'(shf_r.x)
                + vpo_pkg::ACC_W'(shf_r.ctl.den[vpo_pkg::DEN_W-1:1]);
  end

  // range check and restoring divider by 2d
  always_comb begin
    logic [vpo_pkg::HI_W-1:0]  hi;
    vpo_pkg::vpo_div_t         cur;
    logic [vpo_pkg::DEN_W:0]   trial;
    int                        s;
    int                        j;

    // quotient fits in the output only if the top dividend bits stay below 2d
    hi = add_r.a[vpo_pkg::ACC_W-1:vpo_pkg::OUT_W];
    div_nxt[0].qa   = add_r.a[vpo_pkg::OUT_W-1:0];
    div_nxt[0].rem  = add_r.a[vpo_pkg::OUT_W +: vpo_pkg::DEN_W];
    div_nxt[0].den  = add_r.ctl.den;
    div_nxt[0].zero = add_r.ctl.zero;
    div_nxt[0].sat  = add_r.ctl.sat || (hi >= vpo_pkg::HI_W'(add_r.ctl.den));

    for (s = 0; s < DivStg; s++) begin
      cur = div_r[s];
      for (j = 0; j < vpo_pkg::DIV_STEP; j++) begin
        trial = {cur.rem, cur.qa[vpo_pkg::OUT_W-1]};
        if (trial >= {1'b0, cur.den}) begin
          cur.rem = vpo_pkg::DEN_W'(trial - {1'b0, cur.den});
          cur.qa  = {cur.qa[vpo_pkg::OUT_W-2:0], 1'b1};
        end else begin
          cur.rem = trial[vpo_pkg::DEN_W-1:0];
          cur.qa  = {cur.qa[vpo_pkg::OUT_W-2:0], 1'b0};
        end
      end
      div_nxt[s+1] = cur;
    end
  end

  // final select: unused mode wins over saturation
  always_comb begin
    if (div_r[DivStg].zero) begin
      res = '0;
    end else if (div_r[DivStg].sat) begin
      res = vpo_pkg::OUT_MAX;
    end else begin
      res = div_r[DivStg].qa;
    end
  end

  // output register with one skid slot behind it
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_q_nxt    = out_q_r;
    skid_vld_nxt = skid_vld_r;
    skid_q_nxt   = skid_q_r;
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_q_nxt    = skid_q_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_q_nxt   = res;
      end
    end else if (push) begin
      // output held: park the leaving result
      skid_vld_nxt = 1'b1;
      skid_q_nxt   = res;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[NumStg-2:0], in_valid};
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      mul_r <= mul_nxt;
      shf_r <= shf_nxt;
      add_r <= add_nxt;
      div_r <= div_nxt;
    end
    out_q_r  <= out_q_nxt;
    skid_q_r <= skid_q_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_converted = out_q_r;

endmodule

`default_nettype wire

[rtl/vpo_checker.sv]
// vpo_checker: port-level assertions for volt_per_octave_to_frequency, bound to the top level
// depends on vpo_pkg for the result width
`default_nettype none

module vpo_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [vpo_pkg::OUT_W-1:0] out_converted
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_converted))
    else $error("result changed while stalled");

  // input back-pressure only comes from a result waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // the skid slot drains in the cycle after the output is taken
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input still stalled after output transaction");

  // reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind volt_per_octave_to_frequency vpo_checker u_vpo_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// tb_top: self-checking testbench for volt_per_octave_to_frequency, exp2 cv to frequency
// converter; holds its own bit-exact predictor and a random valid/stall driver
// depends on rtl/vpo_pkg.sv and rtl/volt_per_octave_to_frequency.sv
`timescale 1ns / 100ps

module tb_top;

  // codes the package does not name
  localparam logic [vpo_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [vpo_pkg::CFG_IDX_W-1:0] REG_NONE    = 2'd3;

  localparam longint unsigned DIV_20K_HZ   = 64'd20000;
  localparam int              DRAIN_CYCLES = 48;      // covers the pipeline latency, plus margin
  localparam int              DRAIN_LIMIT  = 20000;

  // dut ports; every input has a known value from time zero
  logic                                clk          = 1'b0;
  logic                                rst_n        = 1'b0;
  logic                                in_valid     = 1'b0;
  logic                                in_stall;
  logic signed [vpo_pkg::CV_W-1:0]     in_cv_sample = '0;
  logic                                out_valid;
  logic                                out_stall    = 1'b0;
  logic [vpo_pkg::OUT_W-1:0]           out_converted;
  logic                                cfg_wr_en    = 1'b0;
  logic [vpo_pkg::CFG_IDX_W-1:0]       cfg_index    = vpo_pkg::REG_MODE;
  logic [vpo_pkg::CFG_DATA_W-1:0]      cfg_wdata    = '0;

  // testbench copy of the register file, tracks every write
  logic [vpo_pkg::MODE_W-1:0]          mode_q  = vpo_pkg::MODE_RST;
  logic signed [vpo_pkg::SHIFT_W-1:0]  shift_q = vpo_pkg::SHIFT_RST;
  logic [vpo_pkg::RATE_W-1:0]          rate_q  = vpo_pkg::RATE_RST;

  // table of 2^(2^-(k+1)) in q2.30, filled before reset is released
  longint unsigned                     root_q30 [vpo_pkg::FRAC_W];

  // frequencies predicted for accepted cv transactions, oldest first
  logic [vpo_pkg::OUT_W-1:0]           pending_freq [$];

  int                                  mismatch_count = 0;
  int                                  idle_pct       = 17;   // chance per cycle that the sender idles
  int                                  stall_pct      = 17;   // chance per cycle that the sink stalls

  volt_per_octave_to_frequency u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cv_sample  (in_cv_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_converted (out_converted),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor square root by building the answer one bit at a time from the top
  function automatic longint unsigned sqrt_floor(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    int              b;
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // 2^(cv + shift + 5.0313842) scaled by the output mode, rounded half up, saturated
  function automatic logic [vpo_pkg::OUT_W-1:0] predict_converted(
    input logic signed [vpo_pkg::CV_W-1:0] cv);
    longint          expo;
    int              int_part;
    logic [15:0]     frac;
    longint unsigned mant;
    longint unsigned divisor;
    longint unsigned scaled;
    longint unsigned quo;
    int              sh;
    int              k;
    expo     = longint'(cv) + longint'(shift_q) * 65536 + longint'(vpo_pkg::EXP_OFFSET);
    int_part = int'(expo >>> 16);   // floor, also for negative exponents
    frac     = expo[15:0];

    // mantissa in q2.30: multiply in the root for every set fraction bit, msb first
    mant = 64'd1 << 30;
    for (k = 0; k < vpo_pkg::FRAC_W; k++) begin
      if (frac[15-k]) begin
        mant = (mant * root_q30[k] + (64'd1 << 29)) >> 30;
      end
    end

    // the extra power of two folds the q.30 mantissa into q.24 output scaling
    case (mode_q)
      vpo_pkg::MODE_HZ: begin
        divisor = 64'd1;
        sh      = int_part - 6;
      end
      vpo_pkg::MODE_NYQ: begin
        divisor = longint'(rate_q);
        sh      = int_part - 5;   // twice the frequency
      end
      vpo_pkg::MODE_20K: begin
        divisor = DIV_20K_HZ;
        sh      = int_part - 6;
      end
      default: begin
        return '0;                // unused mode reads as zero
      end
    endcase

    if (divisor == 0) begin
      quo = longint'(vpo_pkg::OUT_MAX);    // zero sample rate pins at full scale
    end else if (sh >= 0) begin
      if (sh > 32) begin
        quo = longint'(vpo_pkg::OUT_MAX);
      end else begin
        scaled = mant << sh;
        quo    = (scaled + divisor / 2) / divisor;
      end
    end else if (-sh >= 40) begin
      quo = '0;
    end else begin
      scaled = divisor << (-sh);
      quo    = (mant + scaled / 2) / scaled;
    end
    if (quo > longint'(vpo_pkg::OUT_MAX)) begin
      quo = longint'(vpo_pkg::OUT_MAX);
    end
    return quo[vpo_pkg::OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // every result transaction is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_freq.size() == 0) begin
        report_mismatch($sformatf("unexpected result converted=%0h", out_converted));
      end else if (out_converted !== pending_freq[0]) begin
        report_mismatch($sformatf("converted got %0h expected %0h",
                                  out_converted, pending_freq[0]));
        void'(pending_freq.pop_front());
      end else begin
        void'(pending_freq.pop_front());
      end
    end
  end

  // sink backpressure, independent of anything the dut drives
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // present one cv sample, hold it until the dut takes it, then predict its result
  task automatic send_cv(input logic signed [vpo_pkg::CV_W-1:0] cv);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) begin
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_cv_sample <= cv;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    // config is frozen while transactions are in flight, so predicting now is safe
    pending_freq.push_back(predict_converted(cv));
  endtask

  // wait for every predicted result, then let the pipeline fall fully idle
  task automatic wait_results_done();
    while (pending_freq.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_wr_en high so back-to-back writes never toggle it within one step
  task automatic write_reg(input logic [vpo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vpo_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      vpo_pkg::REG_MODE:  mode_q  = data[vpo_pkg::MODE_W-1:0];
      vpo_pkg::REG_SHIFT: shift_q = data[vpo_pkg::SHIFT_W-1:0];
      vpo_pkg::REG_RATE:  rate_q  = data[vpo_pkg::RATE_W-1:0];
      default:   ;   // unlisted index, dut must ignore it
    endcase
  endtask

  // full register setup on an idle block; spare data bits are randomized since the
  // dut should only look at the field width, and an ignored index is hit every time
  task automatic configure(input logic [vpo_pkg::MODE_W-1:0] mode_v, input int shift_v,
                           input int rate_v);
    logic [vpo_pkg::CFG_DATA_W-1:0] noise;
    noise = vpo_pkg::CFG_DATA_W'($urandom);
    // stop presenting the last sample before waiting for the block to empty
    in_valid <= 1'b0;
    wait_results_done();
    write_reg(vpo_pkg::REG_MODE,
              {noise[vpo_pkg::CFG_DATA_W-1:vpo_pkg::MODE_W], mode_v});
    write_reg(vpo_pkg::REG_SHIFT,
              {noise[vpo_pkg::CFG_DATA_W-1:vpo_pkg::SHIFT_W], shift_v[vpo_pkg::SHIFT_W-1:0]});
    write_reg(vpo_pkg::REG_RATE, rate_v[vpo_pkg::CFG_DATA_W-1:0]);
    write_reg(REG_NONE, vpo_pkg::CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // mostly in-range voltages, some raw 21-bit patterns, a few extremes
  function automatic logic signed [vpo_pkg::CV_W-1:0] random_cv();
    int pick;
    pick = $urandom_range(99);
    if (pick < 78) begin
      return vpo_pkg::CV_W'(int'($urandom_range(1310720)) - 655360);
    end else if (pick < 92) begin
      return vpo_pkg::CV_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       return {1'b0, {(vpo_pkg::CV_W-1){1'b1}}};
        1:       return {1'b1, {(vpo_pkg::CV_W-1){1'b0}}};
        2:       return vpo_pkg::CV_W'(655360);
        default: return vpo_pkg::CV_W'(-655360);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers untouched since reset: hz mode, no shift, 44.1 kHz
  task automatic test_reset_values();
    send_cv(vpo_pkg::CV_W'(0));
    send_cv(vpo_pkg::CV_W'(65536));
    send_cv(vpo_pkg::CV_W'(-65536));
    send_cv(vpo_pkg::CV_W'(12345));
  endtask

  task automatic test_directed_corners();
    // hz mode: zero volts, range ends, raw extremes, lsb steps, half volt, one lsb under a volt
    configure(vpo_pkg::MODE_HZ, 0, 44100);
    send_cv(vpo_pkg::CV_W'(0));
    send_cv(vpo_pkg::CV_W'(655360));
    send_cv(vpo_pkg::CV_W'(-655360));
    send_cv({1'b0, {(vpo_pkg::CV_W-1){1'b1}}});
    send_cv({1'b1, {(vpo_pkg::CV_W-1){1'b0}}});
    send_cv(vpo_pkg::CV_W'(1));
    send_cv(vpo_pkg::CV_W'(-1));
    send_cv(vpo_pkg::CV_W'(32768));
    send_cv(vpo_pkg::CV_W'(65535));
    // largest shift drives the top of the range into saturation
    configure(vpo_pkg::MODE_HZ, 3, 44100);
    send_cv({1'b0, {(vpo_pkg::CV_W-1){1'b1}}});
    send_cv(vpo_pkg::CV_W'(655360));
    // most negative shift pattern with the lowest input gives the smallest output
    configure(vpo_pkg::MODE_HZ, -4, 44100);
    send_cv({1'b1, {(vpo_pkg::CV_W-1){1'b0}}});
    // nyquist fraction at both ends of the audio rate range
    configure(vpo_pkg::MODE_NYQ, 0, 8000);
    send_cv(vpo_pkg::CV_W'(655360));
    send_cv(vpo_pkg::CV_W'(0));
    configure(vpo_pkg::MODE_NYQ, -3, 192000);
    send_cv(vpo_pkg::CV_W'(-655360));
    send_cv(vpo_pkg::CV_W'(327680));
    // nyquist with a zero rate must pin at full scale
    configure(vpo_pkg::MODE_NYQ, 0, 0);
    send_cv(vpo_pkg::CV_W'(0));
    // all-ones rate exercises every data bit
    configure(vpo_pkg::MODE_NYQ, 2, (1 << vpo_pkg::RATE_W) - 1);
    send_cv(vpo_pkg::CV_W'(655360));
    // fraction of 20 kHz
    configure(vpo_pkg::MODE_20K, 3, 44100);
    send_cv(vpo_pkg::CV_W'(655360));
    send_cv(vpo_pkg::CV_W'(-655360));
    // unused mode always gives zero
    configure(MODE_UNUSED, 1, 44100);
    send_cv(vpo_pkg::CV_W'(655360));
    send_cv(vpo_pkg::CV_W'(0));
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    int pick;
    int mode_v;
    int shift_v;
    int rate_v;
    for (phase = 0; phase < 9; phase++) begin
      pick   = $urandom_range(9);
      mode_v = (pick < 9) ? pick % 3 : MODE_UNUSED;
      if (phase < 3) begin
        mode_v = phase;   // every live mode gets a random phase for sure
      end
      shift_v = int'($urandom_range(7)) - 4;
      pick    = $urandom_range(99);
      if (pick < 70) begin
        rate_v = $urandom_range(192000, 8000);
      end else if (pick < 85) begin
        rate_v = (pick & 1) ? 8000 : 192000;
      end else begin
        rate_v = $urandom_range((1 << vpo_pkg::RATE_W) - 1);
      end
      configure(vpo_pkg::MODE_W'(mode_v), shift_v, rate_v);
      // one phase runs flat out on both sides
      idle_pct  = (phase == 4) ? 0 : 17;
      stall_pct = (phase == 4) ? 0 : 17;
      for (n = 0; n < 100; n++) begin
        send_cv(random_cv());
      end
    end
    idle_pct  = 17;
    stall_pct = 17;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    longint unsigned r;
    int              k;
    int              waited;
    // 2^(2^-(k+1)): each entry is the square root of the previous, kept in q2.30
    r = sqrt_floor(64'd1 << 61);
    for (k = 0; k < vpo_pkg::FRAC_W; k++) begin
      root_q30[k] = r;
      r           = sqrt_floor(r << 30);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed_corners();
    test_random_phases();

    in_valid <= 1'b0;
    waited = 0;
    while (pending_freq.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_freq.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_freq.size()));
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[volt_per_octave_to_frequency.f]
rtl/vpo_pkg.sv
rtl/volt_per_octave_to_frequency.sv
rtl/vpo_checker.sv
sim/tb_top.sv
